// ----- hw/rtl/array_insert_before_key_defines.svh -----
// Assertion macros for the array_insert_before_key block.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef ARRAY_INSERT_BEFORE_KEY_DEFINES_SVH
`define ARRAY_INSERT_BEFORE_KEY_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset
`define AIB_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("aib assertion failed");

// Implication checked at every clock edge out of reset
`define AIB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aib assertion failed");

`else

`define AIB_ASSERT(label, cond)
`define AIB_ASSERT_IMPL(label, ante, cons)

`endif

`endif

// ----- hw/rtl/aib_pkg.sv -----
// Shared types and constants for the array_insert_before_key block.
// No dependencies; used by aib_ctrl, aib_dp and the top level.
package aib_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed request / response field widths
    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int RIDX_W   = 4;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 2'd0,
        FN_INSERT = 2'd1,
        FN_READ   = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_DATA,
        S_SEARCH,
        S_SHIFT,
        S_PUT,
        S_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    search_start;
        logic    search_step;
        logic    shift_start;
        logic    shift_step;
        logic    put;
        logic    append;
        logic    read_issue;
        logic    res_set;
        t_status res_status;
        logic    res_use_rd;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_func              func;
        logic               full;
        logic               empty;
        logic               idx_ok;
        logic               match;
        logic               miss;
        logic               shift_done;
        logic [CNT_W-1:0]   count;
    } t_dp_sts;

endpackage

// ----- hw/rtl/aib_dp.sv -----
// Datapath: request registers, entry memory, search/shift pointers, result regs.
// Depends on aib_pkg; driven by aib_ctrl through t_dp_cmd.
module aib_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aib_pkg::t_dp_cmd                    i_cmd,
    input  logic [aib_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [aib_pkg::DATA_W-1:0]   i_search_key,
    input  logic signed [aib_pkg::DATA_W-1:0]   i_new_value,
    input  logic [aib_pkg::RIDX_W-1:0]          i_read_index,
    output aib_pkg::t_dp_sts                    o_sts,
    output logic [aib_pkg::STAT_W-1:0]          o_status,
    output logic signed [aib_pkg::DATA_W-1:0]   o_read_value,
    output logic [aib_pkg::FILL_W-1:0]          o_fill_count
);
    import aib_pkg::*;

    // Captured request
    t_func                   r_func;
    logic signed [DATA_W-1:0] r_key;
    logic signed [DATA_W-1:0] r_val;
    logic [RIDX_W-1:0]       r_idx;

    // Table state and walk pointers
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rdata;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_ptr;
    logic [CNT_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_rd_pos;
    logic                    r_rd_vld;

    // Pending and delivered result
    t_status                 r_res_status;
    logic signed [DATA_W-1:0] r_res_rd;
    logic [STAT_W-1:0]       r_out_status;
    logic signed [DATA_W-1:0] r_out_rd;
    logic [FILL_W-1:0]       r_out_fill;

    logic                    srch_issue;
    logic                    shift_issue;
    logic                    key_hit;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;

    assign srch_issue  = (r_ptr < r_count);
    assign shift_issue = (r_ptr > r_pos);
    assign key_hit     = r_rd_vld && (r_rdata == r_key);

    // Status back to the controller
    always_comb begin
        o_sts.func       = r_func;
        o_sts.full       = (32'(r_count) >= CAPACITY);
        o_sts.empty      = (r_count == '0);
        o_sts.idx_ok     = (32'(r_idx) < 32'(r_count));
        o_sts.match      = key_hit;
        o_sts.miss       = r_rd_vld && !key_hit && (CNT_W'(r_rd_pos + 1'b1) == r_count);
        o_sts.shift_done = r_rd_vld && !shift_issue;
        o_sts.count      = r_count;
    end

    // Memory write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_val;
        if (i_cmd.append) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_count);
        end else if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_pos);
        end else if (i_cmd.shift_step && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_rd_pos);
            wr_data = r_rdata;
        end
    end

    // Memory read port select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.read_issue) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(r_idx);
        end else if (i_cmd.search_step && srch_issue) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(r_ptr);
        end else if (i_cmd.shift_step && shift_issue) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(r_ptr - 1'b1);
        end
    end

    // Entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control registers: fill count and read-data tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.append || i_cmd.put) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.search_start || i_cmd.shift_start) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.search_step) begin
                r_rd_vld <= srch_issue;
            end else if (i_cmd.shift_step) begin
                r_rd_vld <= shift_issue;
            end
        end
    end

    // Request capture, pointers, result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_func);
            r_key  <= i_search_key;
            r_val  <= i_new_value;
            r_idx  <= i_read_index;
        end
        // search walks up from zero; shift walks down from the count
        if (i_cmd.search_start) begin
            r_ptr <= '0;
        end else if (i_cmd.search_step) begin
            r_rd_pos <= r_ptr;
            if (srch_issue) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end else if (i_cmd.shift_start) begin
            r_ptr <= r_count;
            r_pos <= r_rd_pos;
        end else if (i_cmd.shift_step) begin
            r_rd_pos <= r_ptr;
            if (shift_issue) begin
                r_ptr <= r_ptr - 1'b1;
            end
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_rd     <= i_cmd.res_use_rd ? r_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_rd     <= r_res_rd;
            r_out_fill   <= FILL_W'(r_count);
        end
    end

    assign o_status     = r_out_status;
    assign o_read_value = r_out_rd;
    assign o_fill_count = r_out_fill;

endmodule

// ----- hw/rtl/aib_ctrl.sv -----
// Controller: sequences one request through decode, read or search/shift/put, and result.
// Depends on aib_pkg; commands aib_dp and owns both handshakes.
module aib_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  aib_pkg::t_dp_sts  i_sts,
    output aib_pkg::t_dp_cmd  o_cmd
);
    import aib_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_RESULT;
                if (i_sts.func == FN_INSERT && !i_sts.full && !i_sts.empty) begin
                    n_state = S_SEARCH;
                end else if (i_sts.func == FN_READ && i_sts.idx_ok) begin
                    n_state = S_RD_DATA;
                end
            end
            S_RD_DATA: n_state = S_RESULT;
            S_SEARCH: begin
                if (i_sts.match)     n_state = S_SHIFT;
                else if (i_sts.miss) n_state = S_RESULT;
            end
            S_SHIFT: begin
                if (i_sts.shift_done) n_state = S_PUT;
            end
            S_PUT:    n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                case (i_sts.func)
                    FN_APPEND: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    FN_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else if (i_sts.empty) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_NOTFOUND;
                        end else begin
                            o_cmd.search_start = 1'b1;
                        end
                    end
                    FN_READ: begin
                        if (i_sts.idx_ok) begin
                            o_cmd.read_issue = 1'b1;
                        end else begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                        end
                    end
                    default: begin
                        // unused code: no change, ok status
                        o_cmd.res_set = 1'b1;
                    end
                endcase
            end
            S_RD_DATA: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_use_rd = 1'b1;
            end
            S_SEARCH: begin
                if (i_sts.match) begin
                    o_cmd.shift_start = 1'b1;
                end else if (i_sts.miss) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_NOTFOUND;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
            end
            S_PUT: begin
                o_cmd.put     = 1'b1;
                o_cmd.res_set = 1'b1;
            end
            S_RESULT: begin
                o_cmd.out_load = out_free;
            end
            default: ;
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/array_insert_before_key.sv -----
// Top level of the array_insert_before_key block.
// Depends on aib_pkg, aib_ctrl, aib_dp and array_insert_before_key_defines.svh.
//
//  channel   valid         stall         payload
//  request   i_in_valid    o_in_stall    i_func i_search_key i_new_value i_read_index
//  response  o_out_valid   i_out_stall   o_status o_read_value o_fill_count
//
// One request at a time. Append, failed ops and unused code go from decode straight to
// result, read through a data-read state, insert-before through a search walk over the
// entry memory (a miss ends there), a shift walk, then put and result.
// Synchronous active-low reset clears the fill count and control; entries stay undefined.
// A stalled response holds; the next request is taken while it waits.
module array_insert_before_key (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [aib_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [aib_pkg::DATA_W-1:0]   i_search_key,
    input  logic signed [aib_pkg::DATA_W-1:0]   i_new_value,
    input  logic [aib_pkg::RIDX_W-1:0]          i_read_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [aib_pkg::STAT_W-1:0]          o_status,
    output logic signed [aib_pkg::DATA_W-1:0]   o_read_value,
    output logic [aib_pkg::FILL_W-1:0]          o_fill_count
);
    import aib_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    aib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Table and result datapath
    aib_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_func),
        .i_search_key (i_search_key),
        .i_new_value  (i_new_value),
        .i_read_index (i_read_index),
        .o_sts        (w_sts),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_fill_count (o_fill_count)
    );

    // Checks
`include "array_insert_before_key_defines.svh"

    `AIB_ASSERT(a_count_bound, 32'(w_sts.count) <= CAPACITY)
    `AIB_ASSERT(a_one_writer, $onehot0({w_cmd.append, w_cmd.put, w_cmd.shift_step}))
    `AIB_ASSERT_IMPL(a_full_count, o_out_valid && (o_status == ST_FULL), o_fill_count == FILL_W'(CAPACITY))
    `AIB_ASSERT_IMPL(a_err_zero, o_out_valid && (o_status != ST_OK), o_read_value == '0)

endmodule

// ----- bench/array_insert_before_key_test.sv -----
// Self-checking testbench for array_insert_before_key: directed and random requests.
// Holds a mirror of the entry table and checks every response against it.
// Depends on aib_pkg and the array_insert_before_key RTL.
module array_insert_before_key_test;

    import aib_pkg::*;

    localparam int NUM_RANDOM   = 500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        t_status                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic [FILL_W-1:0]         fill_count;
    } t_table_reply;

    // Clock, reset and block ports
    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    logic [FUNC_W-1:0]           i_func       = '0;
    logic signed [DATA_W-1:0]    i_search_key = '0;
    logic signed [DATA_W-1:0]    i_new_value  = '0;
    logic [RIDX_W-1:0]           i_read_index = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic [STAT_W-1:0]           o_status;
    logic signed [DATA_W-1:0]    o_read_value;
    logic [FILL_W-1:0]           o_fill_count;

    // Mirror of the table and replies still owed by the block
    logic signed [DATA_W-1:0]    mirror_entries [CAPACITY];
    logic [CNT_W-1:0]            mirror_count;
    t_table_reply                replies_owed [$];

    int fail_count     = 0;
    int n_requests     = 0;
    int n_replies      = 0;
    int n_inserted     = 0;
    int n_full         = 0;
    int n_missing      = 0;
    int n_range        = 0;
    int idle_cycles    = 0;
    int in_quiet_left  = 0;
    int out_hold_left  = 0;

    array_insert_before_key dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_search_key (i_search_key),
        .i_new_value  (i_new_value),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_fill_count (o_fill_count)
    );

    always #5 i_clk = ~i_clk;

    // Apply one operation to the mirror and return the reply it should give
    function automatic t_table_reply apply_table_op(t_func op, logic signed [DATA_W-1:0] key,
                                                    logic signed [DATA_W-1:0] val,
                                                    logic [RIDX_W-1:0] idx);
        t_table_reply rep;
        int pos;
        rep.status     = ST_OK;
        rep.read_value = '0;
        case (op)
            FN_APPEND: begin
                if (mirror_count >= CAPACITY) begin
                    rep.status = ST_FULL;
                end else begin
                    mirror_entries[IDX_W'(mirror_count)] = val;
                    mirror_count++;
                end
            end
            FN_INSERT: begin
                // full check comes before the search
                if (mirror_count >= CAPACITY) begin
                    rep.status = ST_FULL;
                end else begin
                    pos = int'(mirror_count);
                    for (int k = int'(mirror_count) - 1; k >= 0; k--)
                        if (mirror_entries[k] == key) pos = k;
                    if (pos == int'(mirror_count)) begin
                        rep.status = ST_NOTFOUND;
                    end else begin
                        for (int k = int'(mirror_count); k > pos; k--)
                            mirror_entries[k] = mirror_entries[k-1];
                        mirror_entries[pos] = val;
                        mirror_count++;
                    end
                end
            end
            FN_READ: begin
                if (idx < mirror_count) rep.read_value = mirror_entries[idx];
                else rep.status = ST_RANGE;
            end
            default: ;
        endcase
        rep.fill_count = mirror_count;
        return rep;
    endfunction

    // Input idle gap: mostly none or short, a few long, with quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_quiet_left > 0) begin
            in_quiet_left--;
            return 0;
        end
        if (r < 10) begin
            in_quiet_left = $urandom_range(5, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Key: usually one already stored, so inserts get past the search
    function automatic logic signed [DATA_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (mirror_count != 0 && r < 70)
            return mirror_entries[$urandom_range(0, mirror_count - 1)];
        return $urandom();
    endfunction

    // Value: sometimes a copy of a stored one, to build duplicate keys
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (mirror_count != 0 && r < 20)
            return mirror_entries[$urandom_range(0, mirror_count - 1)];
        return $urandom();
    endfunction

    function automatic logic [RIDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (mirror_count != 0 && r < 70)
            return RIDX_W'($urandom_range(0, mirror_count - 1));
        return RIDX_W'($urandom_range(0, 15));
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Send one request, wait for it to be taken, then update the mirror
    task automatic send_request(t_func op, logic signed [DATA_W-1:0] key,
                                logic signed [DATA_W-1:0] val, logic [RIDX_W-1:0] idx);
        int gap;
        t_table_reply rep;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= op;
        i_search_key <= key;
        i_new_value  <= val;
        i_read_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rep = apply_table_op(op, key, val, idx);
        replies_owed.push_back(rep);
        n_requests++;
        case (rep.status)
            ST_FULL:     n_full++;
            ST_NOTFOUND: n_missing++;
            ST_RANGE:    n_range++;
            default:     if (op == FN_INSERT) n_inserted++;
        endcase
    endtask

    // Response stall: segments of random level and length
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_out_stall   <= 1'b0;
            out_hold_left <= 0;
        end else if (out_hold_left > 0) begin
            out_hold_left <= out_hold_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                i_out_stall   <= 1'b0;
                out_hold_left <= $urandom_range(5, 25);
            end else if (r < 75) begin
                i_out_stall   <= 1'b1;
                out_hold_left <= $urandom_range(0, 2);
            end else if (r < 95) begin
                i_out_stall   <= 1'b0;
                out_hold_left <= $urandom_range(0, 2);
            end else begin
                i_out_stall   <= 1'b1;
                out_hold_left <= $urandom_range(10, 40);
            end
        end
    end

    // Response checker
    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_replies++;
            if (replies_owed.size() == 0) begin
                $display("MISMATCH at %0t: response with nothing outstanding", $realtime);
                fail_count++;
            end else begin
                want = replies_owed.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", longint'(o_status), longint'(want.status));
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", longint'(o_read_value),
                                    longint'(want.read_value));
                if (o_fill_count !== want.fill_count)
                    report_mismatch("fill_count", longint'(o_fill_count),
                                    longint'(want.fill_count));
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Empty table: every read is out of range, every insert misses
    task automatic test_empty_table();
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd0);
        send_request(FN_READ, -32'sd1, -32'sd1, 4'd15);
        send_request(FN_INSERT, 32'sd0, 32'sd1, 4'd0);
        send_request(FN_NONE, -32'sd1, -32'sd1, 4'd15);
    endtask

    // Appends of extreme values, read back at both ends and past the end
    task automatic test_append_extremes();
        send_request(FN_APPEND, -32'sd1, 32'sh8000_0000, 4'd15);
        send_request(FN_APPEND, 32'sd0, 32'sh7FFF_FFFF, 4'd0);
        send_request(FN_APPEND, 32'sd0, 32'sd0, 4'd0);
        send_request(FN_APPEND, 32'sd0, -32'sd1, 4'd0);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd0);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd3);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd4);
    endtask

    // Insert at the head, before the tail, before a duplicate, and a miss
    task automatic test_insert_before();
        send_request(FN_INSERT, 32'sh8000_0000, 32'sd5, 4'd0);
        send_request(FN_INSERT, -32'sd1, 32'sd7, 4'd0);
        send_request(FN_APPEND, 32'sd0, 32'sh7FFF_FFFF, 4'd0);
        send_request(FN_INSERT, 32'sh7FFF_FFFF, 32'sd9, 4'd0);
        send_request(FN_INSERT, 32'sd12345, 32'sd11, 4'd0);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd0);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd2);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd6);
        send_request(FN_NONE, 32'sh7FFF_FFFF, 32'sh5A5A_A5A5, 4'd7);
    endtask

    // Random traffic, weighted toward reads and inserts with stored keys
    task automatic test_random_traffic(int n);
        int done;
        int r;
        t_func op;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (mirror_count < CAPACITY)
                op = (r < 22) ? FN_INSERT : (r < 28) ? FN_APPEND :
                     (r < 95) ? FN_READ : FN_NONE;
            else
                op = (r < 15) ? FN_INSERT : (r < 30) ? FN_APPEND :
                     (r < 95) ? FN_READ : FN_NONE;
            send_request(op, pick_key(), pick_value(), pick_index());
            if (op != FN_NONE) done++;
        end
    endtask

    // Full table: fill up, then append and insert must both report full
    task automatic test_full_table();
        while (mirror_count < CAPACITY)
            send_request(FN_APPEND, $urandom(), $urandom(), RIDX_W'($urandom_range(0, 15)));
        send_request(FN_APPEND, 32'sd0, 32'sd1, 4'd0);
        send_request(FN_INSERT, mirror_entries[0], 32'sd2, 4'd0);
        send_request(FN_INSERT, 32'sd12345, 32'sd3, 4'd0);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd15);
        send_request(FN_READ, 32'sd0, 32'sd0, 4'd0);
    endtask

    initial begin
        mirror_count = '0;
        foreach (mirror_entries[k]) mirror_entries[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_append_extremes();
        test_insert_before();
        test_random_traffic(NUM_RANDOM);
        test_full_table();
        i_in_valid <= 1'b0;

        while (replies_owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d responses, %0d successful inserts.",
                 n_requests, n_replies, n_inserted);
        $display("Error responses: %0d full, %0d key missing, %0d index out of range.",
                 n_full, n_missing, n_range);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
